>>> rtl/kwpg_pkg.sv
// Shared types and constants for the keyed word packet gatherer.
package kwpg_pkg;

  localparam int WORD_W           = 32;
  localparam int PACKET_WORDS_DEF = 64;
  localparam int QUEUE_DEPTH      = 2;
  localparam int CFG_IDX_W        = 2;

  localparam logic [WORD_W-1:0] END_BIT  = 32'h8000_0000;
  localparam logic [WORD_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEW_SEQ = 2'd0,
    CFG_FIRST   = 2'd1,
    CFG_TRANS   = 2'd2,
    CFG_END     = 2'd3
  } cfg_idx_t;

  // Classified input beat: key matches plus the payload
  typedef struct packed {
    logic              new_seq;
    logic              first_word;
    logic              trans;
    logic              end_key;
    logic [WORD_W-1:0] payload;
  } cmd_t;

endpackage

>>> rtl/kwpg_if.sv
// Valid/ready channel interfaces for the input and result streams.
interface kwpg_in_if;
  logic                        valid;
  logic                        ready;
  logic [kwpg_pkg::WORD_W-1:0] key;
  logic [kwpg_pkg::WORD_W-1:0] payload;

  modport source (output valid, output key, output payload, input ready);
  modport sink   (input valid, input key, input payload, output ready);
endinterface

interface kwpg_out_if;
  logic                        valid;
  logic                        ready;
  logic [kwpg_pkg::WORD_W-1:0] word;
  logic                        last;
  logic                        sequence_over_max;

  modport source (output valid, output word, output last, output sequence_over_max,
                  input ready);
  modport sink   (input valid, input word, input last, input sequence_over_max,
                  output ready);
endinterface

>>> rtl/kwpg_front.sv
// Front end: configuration registers and key classification of input beats.
module kwpg_front (
  input  logic                          clk,
  input  logic                          rst_n,
  kwpg_in_if.sink                       in_ch,
  input  logic                          cfg_we,
  input  logic [kwpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kwpg_pkg::WORD_W-1:0]   cfg_wdata,
  output kwpg_pkg::cmd_t                cmd,
  output logic                          cmd_valid,
  input  logic                          cmd_ready
);
  import kwpg_pkg::*;

  logic [WORD_W-1:0] new_seq_key_r, new_seq_key_nxt;
  logic [WORD_W-1:0] first_key_r, first_key_nxt;
  logic [WORD_W-1:0] trans_key_r, trans_key_nxt;
  logic [WORD_W-1:0] end_key_r, end_key_nxt;

  always_comb begin
    new_seq_key_nxt = new_seq_key_r;
    first_key_nxt   = first_key_r;
    trans_key_nxt   = trans_key_r;
    end_key_nxt     = end_key_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_NEW_SEQ: new_seq_key_nxt = cfg_wdata;
        CFG_FIRST:   first_key_nxt   = cfg_wdata;
        CFG_TRANS:   trans_key_nxt   = cfg_wdata;
        CFG_END:     end_key_nxt     = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      new_seq_key_r <= '0;
      first_key_r   <= '0;
      trans_key_r   <= '0;
      end_key_r     <= '0;
    end else begin
      new_seq_key_r <= new_seq_key_nxt;
      first_key_r   <= first_key_nxt;
      trans_key_r   <= trans_key_nxt;
      end_key_r     <= end_key_nxt;
    end
  end

  always_comb begin
    cmd.new_seq    = (in_ch.key == new_seq_key_r);
    cmd.first_word = (in_ch.key == first_key_r);
    cmd.trans      = (in_ch.key == trans_key_r);
    cmd.end_key    = (in_ch.key == end_key_r);
    cmd.payload    = in_ch.payload;
  end

  assign cmd_valid   = in_ch.valid;
  assign in_ch.ready = cmd_ready;

endmodule

>>> rtl/kwpg_queue.sv
// Short command queue between the front end and the packet engine.
module kwpg_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  kwpg_pkg::cmd_t push_cmd,
  input  logic           push_valid,
  output logic           push_ready,
  output kwpg_pkg::cmd_t pop_cmd,
  output logic           pop_valid,
  input  logic           pop_ready
);
  import kwpg_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> rtl/kwpg_back.sv
// Packet engine: packet state, word store and the flush drain to the output register.
module kwpg_back #(
  parameter int PACKET_WORDS = kwpg_pkg::PACKET_WORDS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  kwpg_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  kwpg_out_if.source     out_ch
);
  import kwpg_pkg::*;

  localparam int FILL_W = $clog2(PACKET_WORDS + 1);
  localparam int ADDR_W = $clog2(PACKET_WORDS);

  typedef enum logic {S_IDLE, S_DRAIN} state_t;

  state_t            state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [WORD_W-1:0] seq_r, seq_nxt;
  logic [WORD_W-1:0] max_r, max_nxt;
  logic [WORD_W-1:0] tid_r, tid_nxt;
  logic [WORD_W-1:0] hdr0_r, hdr0_nxt;
  logic [WORD_W-1:0] hdr1_r, hdr1_nxt;
  logic [WORD_W-1:0] next_seq_r, next_seq_nxt;
  logic [FILL_W-1:0] drain_cnt_r, drain_cnt_nxt;
  logic [FILL_W-1:0] drain_idx_r, drain_idx_nxt;
  logic              drain_over_r, drain_over_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_over_r, out_over_nxt;

  logic [WORD_W-1:0] mem [PACKET_WORDS];
  logic [WORD_W-1:0] mem_q_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  logic              take;
  logic              load;
  logic              word_last;
  logic [FILL_W-1:0] idx_inc;
  logic [FILL_W-1:0] widx;
  logic [FILL_W-1:0] fill_v;
  logic [WORD_W-1:0] seq_v, max_v, tid_v, hdr0_v, hdr1_v;
  logic              flush;
  logic [FILL_W-1:0] flush_cnt;
  logic              flush_over;
  logic [WORD_W-1:0] flush_seq;

  assign cmd_ready = (state_r == S_IDLE);
  assign take      = cmd_valid && cmd_ready;
  assign load      = (state_r == S_DRAIN) && (!out_valid_r || out_ch.ready);
  assign idx_inc   = drain_idx_r + 1'b1;
  assign word_last = (idx_inc == drain_cnt_r);
  assign rd_en     = load;
  assign rd_addr   = idx_inc[ADDR_W-1:0];
  assign widx      = (fill_r >= FILL_W'(PACKET_WORDS)) ? FILL_W'(PACKET_WORDS - 1) : fill_r;
  assign mem_waddr = widx[ADDR_W-1:0];

  // Command evaluation: store, key rules, then flush decision
  always_comb begin
    seq_v      = seq_r;
    max_v      = max_r;
    tid_v      = tid_r;
    hdr0_v     = hdr0_r;
    hdr1_v     = hdr1_r;
    fill_v     = fill_r;
    mem_we     = 1'b0;
    flush      = 1'b0;
    flush_cnt  = fill_r;
    flush_over = (seq_r > max_r);
    flush_seq  = cmd.payload;
    if (take) begin
      if (cmd.new_seq) begin
        // flush of the open packet, then restart with the given sequence
        flush     = 1'b1;
        flush_cnt = (fill_r == FILL_W'(2)) ? '0 : fill_r;
      end else begin
        if (widx == FILL_W'(0)) begin
          hdr0_v = cmd.payload;
        end else if (widx == FILL_W'(1)) begin
          hdr1_v = cmd.payload;
        end else begin
          mem_we = 1'b1;
        end
        fill_v = fill_r + 1'b1;
        if (cmd.first_word) begin
          seq_v  = '0;
          hdr0_v = '0;
          fill_v = FILL_W'(1);
          max_v  = cmd.payload;
        end
        if (cmd.trans) begin
          tid_v  = cmd.payload;
          hdr1_v = cmd.payload;
          fill_v = FILL_W'(2);
        end
        if (cmd.end_key) begin
          hdr0_v = hdr0_v | END_BIT;
          if (fill_v != '0) begin
            fill_v = fill_v - 1'b1;
          end
          flush = 1'b1;
        end else if (fill_v >= FILL_W'(PACKET_WORDS)) begin
          flush = 1'b1;
        end
        flush_cnt  = fill_v;
        flush_over = (seq_v > max_v);
        flush_seq  = seq_v + 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_v;
    seq_nxt        = seq_v;
    max_nxt        = max_v;
    tid_nxt        = tid_v;
    hdr0_nxt       = hdr0_v;
    hdr1_nxt       = hdr1_v;
    next_seq_nxt   = next_seq_r;
    drain_cnt_nxt  = drain_cnt_r;
    drain_idx_nxt  = drain_idx_r;
    drain_over_nxt = drain_over_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_word_nxt   = out_word_r;
    out_last_nxt   = out_last_r;
    out_over_nxt   = out_over_r;

    if (flush) begin
      if (flush_cnt == '0) begin
        seq_nxt  = flush_seq;
        hdr0_nxt = flush_seq;
        hdr1_nxt = tid_v;
        fill_nxt = FILL_W'(2);
      end else begin
        state_nxt      = S_DRAIN;
        next_seq_nxt   = flush_seq;
        drain_cnt_nxt  = flush_cnt;
        drain_idx_nxt  = '0;
        drain_over_nxt = flush_over;
      end
    end

    if (load) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = word_last;
      out_over_nxt  = drain_over_r;
      if (drain_idx_r == FILL_W'(0)) begin
        out_word_nxt = hdr0_r;
      end else if (drain_idx_r == FILL_W'(1)) begin
        out_word_nxt = hdr1_r;
      end else begin
        out_word_nxt = mem_q_r;
      end
      drain_idx_nxt = idx_inc;
      if (word_last) begin
        // header reload once the packet has gone out
        state_nxt = S_IDLE;
        seq_nxt   = next_seq_r;
        hdr0_nxt  = next_seq_r;
        hdr1_nxt  = tid_r;
        fill_nxt  = FILL_W'(2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      seq_r        <= '0;
      max_r        <= ALL_ONES;
      tid_r        <= '0;
      hdr0_r       <= '0;
      hdr1_r       <= '0;
      next_seq_r   <= '0;
      drain_cnt_r  <= '0;
      drain_idx_r  <= '0;
      drain_over_r <= 1'b0;
      out_valid_r  <= 1'b0;
      out_word_r   <= '0;
      out_last_r   <= 1'b0;
      out_over_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      seq_r        <= seq_nxt;
      max_r        <= max_nxt;
      tid_r        <= tid_nxt;
      hdr0_r       <= hdr0_nxt;
      hdr1_r       <= hdr1_nxt;
      next_seq_r   <= next_seq_nxt;
      drain_cnt_r  <= drain_cnt_nxt;
      drain_idx_r  <= drain_idx_nxt;
      drain_over_r <= drain_over_nxt;
      out_valid_r  <= out_valid_nxt;
      out_word_r   <= out_word_nxt;
      out_last_r   <= out_last_nxt;
      out_over_r   <= out_over_nxt;
    end
  end

  // Data words only; the two header words live in hdr0_r/hdr1_r
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= cmd.payload;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.word              = out_word_r;
  assign out_ch.last              = out_last_r;
  assign out_ch.sequence_over_max = out_over_r;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(PACKET_WORDS))
    else $error("fill position beyond packet size");

  a_drain_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRAIN |-> drain_idx_r < drain_cnt_r && drain_cnt_r != '0)
    else $error("drain index outside packet");

  a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
    load && word_last |=> state_r == S_IDLE && fill_r == FILL_W'(2) && out_ch.last)
    else $error("packet end did not reload header");

  a_no_take_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRAIN |-> !take && !mem_we)
    else $error("command taken during drain");
`endif

endmodule

>>> rtl/keyed_word_packet_gatherer.sv
// Top level of the keyed word packet gatherer.
//
// in_ch carries (key, payload) beats; out_ch carries packet words with a
// last flag and a sequence_over_max flag that is constant over a packet.
// cfg_we/cfg_index/cfg_wdata write the four special keys; write them only
// while no beat is in flight.
// An accepted beat enters a two-entry command queue and is registered there
// before the packet engine executes it. A beat that does not flush leaves
// the engine free for the next beat. A flushing beat of N stored words holds
// the engine until all N words are out: once the beat is taken from the queue
// the state register moves to drain, then the first word is registered on
// out_ch, then one word per cycle while out_ch.ready is high. Throughput is
// bounded by the single word store: no new beat is executed until the packet
// has been read out. The input keeps accepting until the queue is full, so
// in_ch.ready drops only when the engine is draining or out_ch is stalled long enough.
// A stall on out_ch holds the output register and pauses the drain.
// Reset (rst_n low, synchronous) clears the keys, the queue, the fill
// position, sequence number and transaction id, and sets the maximum
// sequence to all ones; no clearing pass is needed.
module keyed_word_packet_gatherer #(
  parameter int PACKET_WORDS = kwpg_pkg::PACKET_WORDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  kwpg_in_if.sink                        in_ch,
  kwpg_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [kwpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kwpg_pkg::WORD_W-1:0]    cfg_wdata
);
  import kwpg_pkg::*;

  cmd_t front_cmd;
  logic front_valid;
  logic front_ready;
  cmd_t back_cmd;
  logic back_valid;
  logic back_ready;

  kwpg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready)
  );

  kwpg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cmd   (front_cmd),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_cmd    (back_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  kwpg_back #(
    .PACKET_WORDS (PACKET_WORDS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (back_cmd),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .out_ch    (out_ch)
  );

endmodule

>>> tb/kwpg_packet_checker.sv
// Watches both streams and the key port, predicts packet words, compares results.
`timescale 1ns / 1ps
module kwpg_packet_checker #(
  parameter int PACKET_WORDS = kwpg_pkg::PACKET_WORDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  kwpg_in_if                             in_ch,
  kwpg_out_if                            out_ch,
  input  logic                           cfg_we,
  input  logic [kwpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kwpg_pkg::WORD_W-1:0]    cfg_wdata,
  output int                             mismatches,
  output int                             words_pending,
  output int                             words_seen
);
  import kwpg_pkg::*;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              last;
    logic              over;
  } packet_word_t;

  packet_word_t      expected_words[$];
  packet_word_t      want;
  logic [WORD_W-1:0] word_store [PACKET_WORDS];
  logic [6:0]        fill_pos;
  logic [WORD_W-1:0] seq_num;
  logic [WORD_W-1:0] max_seq;
  logic [WORD_W-1:0] trans_id;
  logic [WORD_W-1:0] special_key [4];
  int                k;

  task automatic reload_header();
    word_store[0] = seq_num;
    word_store[1] = trans_id;
    fill_pos      = 7'd2;
  endtask

  // Queue up every stored word, then move on to the next sequence number
  task automatic flush_packet();
    int           count;
    int           i;
    logic         over;
    packet_word_t w;
    count = (fill_pos > PACKET_WORDS) ? PACKET_WORDS : int'(fill_pos);
    over  = (seq_num > max_seq);
    for (i = 0; i < count; i++) begin
      w.word = word_store[i];
      w.last = (i == count - 1);
      w.over = over;
      expected_words.push_back(w);
    end
    seq_num = seq_num + 1'b1;
    reload_header();
  endtask

  task automatic take_beat(input logic [WORD_W-1:0] key, input logic [WORD_W-1:0] payload);
    int slot;
    if (key == special_key[CFG_NEW_SEQ]) begin
      if (fill_pos != 7'd2) flush_packet();
      seq_num = payload;
      reload_header();
    end else begin
      slot = (fill_pos >= PACKET_WORDS) ? PACKET_WORDS - 1 : int'(fill_pos);
      word_store[slot] = payload;
      fill_pos = fill_pos + 7'd1;
      // the remaining key rules are not exclusive: all that match apply, in order
      if (key == special_key[CFG_FIRST]) begin
        seq_num       = '0;
        word_store[0] = '0;
        fill_pos      = 7'd1;
        max_seq       = payload;
      end
      if (key == special_key[CFG_TRANS]) begin
        trans_id      = payload;
        word_store[1] = payload;
        fill_pos      = 7'd2;
      end
      if (key == special_key[CFG_END]) begin
        word_store[0] = word_store[0] | END_BIT;
        if (fill_pos > 0) fill_pos = fill_pos - 7'd1;
        flush_packet();
      end else if (fill_pos >= PACKET_WORDS) begin
        flush_packet();
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (k = 0; k < PACKET_WORDS; k++) word_store[k] = '0;
      for (k = 0; k < 4; k++) special_key[k] = '0;
      fill_pos = '0;
      seq_num  = '0;
      max_seq  = ALL_ONES;
      trans_id = '0;
      expected_words.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          $error("unexpected packet word %h", out_ch.word);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (out_ch.word !== want.word) begin
            $error("word: expected %h, actual %h", want.word, out_ch.word);
            mismatches++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, out_ch.last);
            mismatches++;
          end
          if (out_ch.sequence_over_max !== want.over) begin
            $error("sequence_over_max: expected %b, actual %b", want.over,
                   out_ch.sequence_over_max);
            mismatches++;
          end
        end
      end
      if (cfg_we) special_key[cfg_index] = cfg_wdata;
      if (in_ch.valid && in_ch.ready) take_beat(in_ch.key, in_ch.payload);
    end
    words_pending = expected_words.size();
  end
endmodule

>>> tb/tb.sv
// Stimulus and verdict for the keyed word packet gatherer.
`timescale 1ns / 1ps
module tb;
  import kwpg_pkg::*;

  localparam int PHASES      = 6;
  localparam int PHASE_BEATS = 73;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_wdata;

  int                in_idle_pct;
  int                out_idle_pct;
  int                beats_sent;
  int                directed_beats;
  int                key_settings;
  int                phase;
  logic [WORD_W-1:0] shared_key;
  logic [WORD_W-1:0] cur_key [4];

  int mismatches;
  int words_pending;
  int words_seen;

  kwpg_in_if  in_ch ();
  kwpg_out_if out_ch ();

  keyed_word_packet_gatherer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  kwpg_packet_checker packet_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .words_pending (words_pending),
    .words_seen    (words_seen)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return ALL_ONES;
      default: return $urandom();
    endcase
  endfunction

  // Called and returns at a falling edge; valid is left high for the next beat
  task automatic send_beat(input logic [WORD_W-1:0] key, input logic [WORD_W-1:0] payload);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.key     <= key;
    in_ch.payload <= payload;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  // Drain everything, then allow for beats still queued that flush nothing
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic program_keys(input logic [WORD_W-1:0] k_new, input logic [WORD_W-1:0] k_first,
                              input logic [WORD_W-1:0] k_trans, input logic [WORD_W-1:0] k_end);
    logic [WORD_W-1:0] vals [4];
    int                i;
    vals[CFG_NEW_SEQ] = k_new;
    vals[CFG_FIRST]   = k_first;
    vals[CFG_TRANS]   = k_trans;
    vals[CFG_END]     = k_end;
    wait_idle();
    for (i = 0; i < 4; i++) begin
      cfg_we     <= 1'b1;
      cfg_index  <= cfg_idx_t'(i);
      cfg_wdata  <= vals[i];
      cur_key[i]  = vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    key_settings++;
  endtask

  // Header keys, some data, then mostly an end key
  task automatic run_stream();
    int n_data;
    int i;
    if ($urandom_range(1) == 1) begin
      send_beat(cur_key[CFG_NEW_SEQ], rand_word());
    end else begin
      send_beat(cur_key[CFG_FIRST], ($urandom_range(3) == 0) ? $urandom() : $urandom_range(8));
      if ($urandom_range(9) < 7) send_beat(cur_key[CFG_TRANS], rand_word());
    end
    // a few streams run past a full buffer
    n_data = ($urandom_range(9) == 0) ? $urandom_range(58, 66) : $urandom_range(10);
    for (i = 0; i < n_data; i++) send_beat($urandom(), rand_word());
    case ($urandom_range(9))
      7, 8:    send_beat(cur_key[CFG_NEW_SEQ], rand_word());
      9:       ;
      default: send_beat(cur_key[CFG_END], rand_word());
    endcase
  endtask

  task automatic noise_beat();
    int sel;
    sel = $urandom_range(4);
    if (sel < 4) send_beat(cur_key[sel], rand_word());
    else send_beat($urandom(), rand_word());
  endtask

  initial begin
    #5_000_000;
    $display("tb failed");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_NEW_SEQ;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.key     = '0;
    in_ch.payload = '0;
    in_idle_pct   = 30;
    out_idle_pct  = 57;
    beats_sent    = 0;
    key_settings  = 0;
    for (phase = 0; phase < 4; phase++) cur_key[phase] = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Out of reset every key is zero, so key 0 means new sequence
    send_beat(32'h0000_0000, 32'h0000_0005);  // empty flush
    send_beat(32'h0000_0001, ALL_ONES);
    send_beat(32'h0000_0000, ALL_ONES);       // flushes three words
    send_beat(32'h0000_0000, 32'h0000_0000);  // header only, no flush

    program_keys(32'h0000_0000, ALL_ONES, 32'h5555_5555, 32'hAAAA_AAAA);
    send_beat(cur_key[CFG_FIRST], 32'h0000_0003);
    send_beat(cur_key[CFG_TRANS], ALL_ONES);
    send_beat(32'h1234_5678, 32'h0000_0000);
    send_beat(32'h1234_5678, ALL_ONES);
    send_beat(cur_key[CFG_END], 32'hCAFE_F00D);
    // top sequence number: flagged over max, then wraps to zero
    send_beat(cur_key[CFG_NEW_SEQ], ALL_ONES);
    send_beat(32'h1234_5678, 32'h0000_0001);
    send_beat(cur_key[CFG_END], 32'h0000_0000);
    send_beat(cur_key[CFG_END], ALL_ONES);    // header-only packet
    send_beat(cur_key[CFG_FIRST], 32'h0000_0000);
    send_beat(cur_key[CFG_END], 32'h0F0F_0F0F);  // single-word packet
    send_beat(cur_key[CFG_NEW_SEQ], 32'h0000_0007);
    send_beat(32'h1234_5678, 32'h8000_0000);
    send_beat(32'h1234_5678, 32'h7FFF_FFFF);
    send_beat(cur_key[CFG_NEW_SEQ], 32'h0000_0009);  // new sequence flushes
    directed_beats = beats_sent;

    for (phase = 0; phase < PHASES; phase++) begin
      shared_key = $urandom();
      case (phase)
        1:       program_keys(ALL_ONES, '0, $urandom(), $urandom());
        2:       program_keys($urandom(), shared_key, $urandom(), shared_key);
        3:       program_keys($urandom(), $urandom(), shared_key, shared_key);
        4:       program_keys($urandom(), shared_key, shared_key, shared_key);
        default: program_keys($urandom(), $urandom(), $urandom(), $urandom());
      endcase
      while (beats_sent < directed_beats + PHASE_BEATS * (phase + 1)) begin
        if (beats_sent < 170) begin
          in_idle_pct  = 30;
          out_idle_pct = 57;
        end else if (beats_sent < 320) begin
          in_idle_pct  = 57;
          out_idle_pct = 30;
        end else begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
        if ($urandom_range(4) == 0) noise_beat();
        else run_stream();
      end
    end
    wait_idle();

    $display("Sent %0d key/payload beats (%0d directed) under %0d key settings,",
             beats_sent, directed_beats, key_settings);
    $display("with stalls on both sides; %0d packet words compared.", words_seen);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
